[sv/mex_tracker_top_macros.svh]
// Assertion macros shared by the mex tracker modules.
`ifndef MEX_TRACKER_TOP_MACROS_SVH
`define MEX_TRACKER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MEX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MEX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) ante |=> cons) else $error(msg);
`else
`define MEX_ASSERT(lbl, prop, msg)
`define MEX_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[sv/mex_pkg.sv]
// Shared constants, types and functions of the mex tracker.
package mex_pkg;

  localparam int MAX_VALUES_DEF = 1024;
  localparam int COUNT_BITS_DEF = 16;

  localparam int LIMIT_BITS = 11;
  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 11'd1024;

  localparam int IN_DATA_BITS  = 32;
  localparam int OUT_DATA_BITS = 16;

  localparam int WORD_BITS = 32;
  localparam int WORD_SEL  = 5;

  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_RANGE  = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;
  localparam logic [1:0] ST_SAT    = 2'd3;

  typedef struct packed {
    logic clr_step;
    logic capture;
    logic rd_req;
    logic update;
    logic scan_start;
    logic scan_step;
    logic load_out;
  } mex_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic in_range;
    logic need_scan;
    logic scan_done;
    logic out_free;
  } mex_sts_t;

  // Index of the lowest clear bit of a bitmap word; zero when none is clear.
  function automatic logic [WORD_SEL-1:0] ffz_word(input logic [WORD_BITS-1:0] w);
    logic [WORD_SEL-1:0] pos;
    pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!w[i]) pos = WORD_SEL'(i);
    end
    return pos;
  endfunction

endpackage

[sv/mex_tracker_top.sv]
// Mex tracker: an out of range word goes from capture straight to the finish state and the output register,
// while a tracked one first passes the read and update states of the count store read-modify-write.
// An add that fills the current mex adds a scan-start state and a scan over bitmap words of 32 values.
// One word is handled at a time; the next word is taken while a result waits.
// Reset is synchronous; afterwards a clearing pass over every count entry zeroes the stores
// with s_tready low, while configuration writes are still taken.
module mex_tracker_top #(
  parameter int MAX_VALUES = mex_pkg::MAX_VALUES_DEF,
  parameter int COUNT_BITS = mex_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [mex_pkg::LIMIT_BITS-1:0]    cfg_wdata,   // tracked_limit
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [mex_pkg::IN_DATA_BITS-1:0]  s_tdata,     // [31:0] value
  input  logic                              s_tuser,     // [0] cmd
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [mex_pkg::OUT_DATA_BITS-1:0] m_tdata,     // [10:0] mex_value, rest zero
  output logic [1:0]                        m_tuser      // [1:0] status
);

  mex_pkg::mex_cmd_t ctl;
  mex_pkg::mex_sts_t sts;

  mex_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .ctl      (ctl)
  );

  mex_dp #(
    .MAX_VALUES (MAX_VALUES),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .ctl       (ctl),
    .sts       (sts)
  );

endmodule

[sv/mex_ctrl.sv]
// Control state machine of the mex tracker.
`include "mex_tracker_top_macros.svh"
module mex_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  mex_pkg::mex_sts_t  sts,
  output mex_pkg::mex_cmd_t  ctl
);

  localparam logic [2:0] S_CLEAR      = 3'd0;
  localparam logic [2:0] S_IDLE       = 3'd1;
  localparam logic [2:0] S_READ       = 3'd2;
  localparam logic [2:0] S_UPDATE     = 3'd3;
  localparam logic [2:0] S_SCAN_START = 3'd4;
  localparam logic [2:0] S_SCAN       = 3'd5;
  localparam logic [2:0] S_FINISH     = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    state_next = state;
    ctl = '0;
    unique case (state)
      S_CLEAR: begin
        ctl.clr_step = 1'b1;
        if (sts.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_tvalid) begin
          ctl.capture = 1'b1;
          state_next = sts.in_range ? S_READ : S_FINISH;
        end
      end
      S_READ: begin
        ctl.rd_req = 1'b1;
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        ctl.update = 1'b1;
        state_next = sts.need_scan ? S_SCAN_START : S_FINISH;
      end
      S_SCAN_START: begin
        ctl.scan_start = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        ctl.scan_step = 1'b1;
        if (sts.scan_done) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          ctl.load_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == S_IDLE);

  `MEX_ASSERT(a_load_free, ctl.load_out |-> sts.out_free, "result loaded while output busy")
  `MEX_ASSERT_NEXT(a_range_skip, (s_tready && s_tvalid && !sts.in_range), (state == S_FINISH), "out of range word touched the count store")

endmodule

[sv/mex_dp.sv]
// Datapath of the mex tracker: count store, presence bitmap, mex scan and output register.
`include "mex_tracker_top_macros.svh"
module mex_dp #(
  parameter int MAX_VALUES = mex_pkg::MAX_VALUES_DEF,
  parameter int COUNT_BITS = mex_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [mex_pkg::LIMIT_BITS-1:0]      cfg_wdata,
  input  logic [mex_pkg::IN_DATA_BITS-1:0]    s_tdata,
  input  logic                                s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [mex_pkg::OUT_DATA_BITS-1:0]   m_tdata,
  output logic [1:0]                          m_tuser,
  input  mex_pkg::mex_cmd_t                   ctl,
  output mex_pkg::mex_sts_t                   sts
);

  localparam int WB     = mex_pkg::WORD_BITS;
  localparam int WS     = mex_pkg::WORD_SEL;
  localparam int IDXW   = $clog2(MAX_VALUES);
  localparam int NWORDS = (MAX_VALUES + WB - 1) / WB;
  localparam int WAW    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int POSW   = WAW + WS;
  localparam int GW     = $clog2(MAX_VALUES + 1);
  localparam int LB     = mex_pkg::LIMIT_BITS;
  localparam int LW     = (GW > LB) ? GW : LB;

  logic [COUNT_BITS-1:0] cnt_mem [MAX_VALUES];
  logic [WB-1:0]         bm_mem  [NWORDS];

  logic [LB-1:0]         limit_reg;
  logic                  cmd_q;
  logic [IDXW-1:0]       idx_q;
  logic [1:0]            status_q;
  logic [COUNT_BITS-1:0] cnt_rd;
  logic [WB-1:0]         bm_rd;
  logic [GW-1:0]         gmex;
  logic [WAW-1:0]        scan_addr;
  logic [IDXW-1:0]       clr_cnt;

  logic [POSW-1:0]       idx_pos;
  logic [WAW-1:0]        idx_word;
  logic [WS-1:0]         idx_bit;
  logic [POSW-1:0]       clr_pos;
  logic [WAW-1:0]        clr_word;
  logic [WAW-1:0]        scan_next;
  logic [POSW-1:0]       scan_pos;
  logic                  scan_hit;
  logic                  scan_last;
  logic [GW-1:0]         scan_mex;
  logic [COUNT_BITS-1:0] cnt_new;
  logic [1:0]            upd_st;
  logic [WB-1:0]         word_new;
  logic [LW-1:0]         cfg_ext;
  logic [LW-1:0]         lim_eff;
  logic [LW-1:0]         gmex_ext;
  logic [LW-1:0]         mex_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_reg <= mex_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      limit_reg <= cfg_wdata;
    end
  end

  // A limit above the store capacity acts as the capacity.
  assign cfg_ext  = LW'(limit_reg);
  assign lim_eff  = (cfg_ext > LW'(MAX_VALUES)) ? LW'(MAX_VALUES) : cfg_ext;
  assign gmex_ext = LW'(gmex);
  assign mex_full = (gmex_ext < lim_eff) ? gmex_ext : lim_eff;

  assign idx_pos  = POSW'(idx_q);
  assign idx_word = idx_pos[POSW-1:WS];
  assign idx_bit  = idx_pos[WS-1:0];
  assign clr_pos  = POSW'(clr_cnt);
  assign clr_word = clr_pos[POSW-1:WS];

  assign scan_next = scan_addr + WAW'(1);
  assign scan_pos  = {scan_addr, mex_pkg::ffz_word(bm_rd)};
  assign scan_hit  = ~&bm_rd;
  assign scan_last = (scan_addr == WAW'(NWORDS - 1));
  assign scan_mex  = ((POSW+1)'(scan_pos) >= (POSW+1)'(MAX_VALUES)) ?
                     GW'(MAX_VALUES) : GW'(scan_pos);

  always_comb begin
    cnt_new = cnt_rd;
    upd_st  = mex_pkg::ST_OK;
    if (cmd_q == mex_pkg::CMD_ADD) begin
      if (&cnt_rd) upd_st = mex_pkg::ST_SAT;
      else cnt_new = cnt_rd + COUNT_BITS'(1);
    end else begin
      if (cnt_rd == '0) upd_st = mex_pkg::ST_ABSENT;
      else cnt_new = cnt_rd - COUNT_BITS'(1);
    end
    word_new = bm_rd;
    word_new[idx_bit] = (cnt_new != '0);
  end

  always_comb begin
    sts.clr_done  = (clr_cnt == IDXW'(MAX_VALUES - 1));
    sts.in_range  = (s_tdata < mex_pkg::IN_DATA_BITS'(lim_eff));
    // The current mex just became present, so the next clear bit must be found.
    sts.need_scan = (cmd_q == mex_pkg::CMD_ADD) && (cnt_rd == '0) && (GW'(idx_q) == gmex);
    sts.scan_done = scan_hit || scan_last;
    sts.out_free  = !m_tvalid || m_tready;
  end

  always_ff @(posedge clk) begin
    if (ctl.clr_step) begin
      cnt_mem[clr_cnt] <= '0;
    end else if (ctl.update) begin
      cnt_mem[idx_q] <= cnt_new;
    end
    if (ctl.rd_req) cnt_rd <= cnt_mem[idx_q];
  end

  always_ff @(posedge clk) begin
    if (ctl.clr_step) begin
      bm_mem[clr_word] <= '0;
    end else if (ctl.update) begin
      bm_mem[idx_word] <= word_new;
    end
    if (ctl.rd_req || ctl.scan_start) begin
      bm_rd <= bm_mem[idx_word];
    end else if (ctl.scan_step && !sts.scan_done) begin
      bm_rd <= bm_mem[scan_next];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_q    <= s_tuser;
      idx_q    <= s_tdata[IDXW-1:0];
      status_q <= sts.in_range ? mex_pkg::ST_OK : mex_pkg::ST_RANGE;
    end else if (ctl.update) begin
      status_q <= upd_st;
    end
    if (ctl.scan_start) begin
      scan_addr <= idx_word;
    end else if (ctl.scan_step) begin
      scan_addr <= scan_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      gmex    <= '0;
    end else begin
      if (ctl.clr_step) clr_cnt <= clr_cnt + IDXW'(1);
      if (ctl.update && cmd_q == mex_pkg::CMD_REMOVE && cnt_new == '0 &&
          GW'(idx_q) < gmex) begin
        gmex <= GW'(idx_q);
      end else if (ctl.scan_step && sts.scan_done) begin
        gmex <= scan_hit ? scan_mex : GW'(MAX_VALUES);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctl.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (ctl.load_out) begin
      m_tdata <= mex_pkg::OUT_DATA_BITS'(mex_full[LB-1:0]);
      m_tuser <= status_q;
    end
  end

  `MEX_ASSERT(a_gmex_bound, gmex <= GW'(MAX_VALUES), "mex register beyond capacity")
  `MEX_ASSERT(a_clear_quiet, ctl.clr_step |-> !m_tvalid, "result offered during clearing pass")

endmodule
